>>> rtl/core/assert_macros.svh
// Assertion macros shared by the line editor RTL.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define SLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check at every edge, reset included
`define SLE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/sle_pkg.sv
// Shared types and constants for the serial line editor.
// No dependencies; imported by every module of the block.
package sle_pkg;

  localparam int LINE_DEPTH_DEF = 32;

  localparam logic [5:0] LINE_SIZE_RST = 6'd32;
  localparam int         REG_LINE_SIZE = 0;

  localparam logic [7:0] K_BS    = 8'h08;
  localparam logic [7:0] K_LF    = 8'h0A;
  localparam logic [7:0] K_CR    = 8'h0D;
  localparam logic [7:0] K_XON   = 8'h11;
  localparam logic [7:0] K_XOFF  = 8'h13;
  localparam logic [7:0] K_ESC   = 8'h1B;
  localparam logic [7:0] K_DEL   = 8'h7F;
  localparam logic [7:0] K_SPACE = 8'h20;

  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ABORT = 2'd3;

  typedef enum logic [2:0] {
    KC_IGNORE,
    KC_ERASE,
    KC_ABORT,
    KC_CR,
    KC_PLAIN
  } key_class_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_ECHO,
    EMIT_LINE,
    EMIT_DONE,
    EMIT_ABORT
  } emit_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE_LF,
    S_CHECK,
    S_ECHO,
    S_PREP,
    S_DUMP,
    S_DONE,
    S_ABORT
  } state_t;

  typedef struct packed {
    logic  accept;
    logic  store_key;
    logic  store_lf;
    logic  dec_count;
    logic  clr_count;
    logic  check;
    logic  rd_first;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    key_class_t cls;
    logic       count_zero;
    logic       ended_now;
    logic       ended;
    logic       has_echo;
    logic       echo_last;
    logic       dump_last;
    logic       slot_free;
  } sts_t;

  function automatic key_class_t classify(input logic [7:0] c);
    key_class_t k;
    unique case (c)
      K_XON, K_XOFF: k = KC_IGNORE;
      K_BS, K_DEL:   k = KC_ERASE;
      K_ESC:         k = KC_ABORT;
      K_CR:          k = KC_CR;
      default:       k = KC_PLAIN;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/core/sle_datapath.sv
// Datapath of the line editor: line store, count, echo sequencer, output register.
// Depends on sle_pkg and assert_macros.svh; driven by sle_ctrl commands.
`include "assert_macros.svh"

module sle_datapath
  import sle_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [7:0] key_char,
  input  logic [5:0] line_size,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [1:0] result_kind,
  output logic [7:0] result_byte,
  output logic       last_of_run
);

  localparam int AW   = $clog2(LINE_DEPTH);
  localparam int SZ_W = 7;

  logic [7:0]    mem [LINE_DEPTH];
  logic [AW-1:0] count;
  logic [AW-1:0] count_next;
  logic [AW-1:0] idx;
  logic [AW-1:0] idx_inc;
  logic [7:0]    rdata;
  logic [7:0]    chr;
  logic [1:0]    echo_n;
  logic          echo_erase;
  logic          ended;
  logic          wr_en;
  logic [7:0]    wdata;
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic [SZ_W-1:0] size_ext;
  logic [SZ_W-1:0] size_clamp;
  logic [SZ_W-1:0] limit;
  logic          room;
  logic          ld;
  logic [1:0]    ld_kind;
  logic [7:0]    ld_byte;
  logic          ld_last;
  key_class_t    cls;

  assign cls     = classify(key_char);
  assign idx_inc = idx + 1'b1;
  assign room    = count < AW'(LINE_DEPTH - 1);

  always_comb begin
    size_ext = {1'b0, line_size};
    if (size_ext < SZ_W'(3)) begin
      size_clamp = SZ_W'(3);
    end else if (size_ext > SZ_W'(LINE_DEPTH)) begin
      size_clamp = SZ_W'(LINE_DEPTH);
    end else begin
      size_clamp = size_ext;
    end
    limit = size_clamp - SZ_W'(2);
  end

  assign sts.cls        = cls;
  assign sts.count_zero = (count == '0);
  assign sts.ended_now  = (chr == K_LF) || (SZ_W'(count) >= limit);
  assign sts.ended      = ended;
  assign sts.has_echo   = (echo_n != 2'd0);
  assign sts.echo_last  = (echo_n == 2'd1);
  assign sts.dump_last  = (idx_inc == count);
  assign sts.slot_free  = !result_valid || result_ready;

  assign wr_en = (cmd.store_key || cmd.store_lf) && room;
  assign wdata = cmd.store_lf ? K_LF : key_char;
  assign rd_en = cmd.rd_first || (cmd.emit == EMIT_LINE);
  assign raddr = cmd.rd_first ? '0 : idx_inc;

  always_comb begin
    count_next = count;
    if (cmd.clr_count || cmd.emit == EMIT_DONE) begin
      count_next = '0;
    end else if (wr_en) begin
      count_next = count + 1'b1;
    end else if (cmd.dec_count) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      echo_n <= 2'd0;
      ended  <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.accept) begin
        unique case (cls)
          KC_ERASE:        echo_n <= (count == '0) ? 2'd0 : 2'd3;
          KC_CR, KC_PLAIN: echo_n <= 2'd1;
          default:         echo_n <= 2'd0;
        endcase
      end else if (cmd.emit == EMIT_ECHO) begin
        echo_n <= echo_n - 2'd1;
      end
      if (cmd.check) begin
        ended <= sts.ended_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      chr        <= (cls == KC_CR) ? K_LF : key_char;
      echo_erase <= (cls == KC_ERASE);
    end
    if (cmd.rd_first) begin
      idx <= '0;
    end else if (cmd.emit == EMIT_LINE) begin
      idx <= idx_inc;
    end
  end

  always_comb begin
    ld      = 1'b1;
    ld_kind = KIND_ECHO;
    ld_byte = 8'h00;
    ld_last = 1'b0;
    unique case (cmd.emit)
      EMIT_ECHO: begin
        ld_byte = echo_erase ? ((echo_n == 2'd2) ? K_SPACE : K_BS) : chr;
        ld_last = (echo_n == 2'd1) && !ended;
      end
      EMIT_LINE: begin
        ld_kind = KIND_LINE;
        ld_byte = rdata;
      end
      EMIT_DONE: begin
        ld_kind = KIND_DONE;
        ld_last = 1'b1;
      end
      EMIT_ABORT: begin
        ld_kind = KIND_ABORT;
        ld_last = 1'b1;
      end
      default: ld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ld) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      result_kind <= ld_kind;
      result_byte <= ld_byte;
      last_of_run <= ld_last;
    end
  end

  `SLE_ASSERT(a_line_in_range, (cmd.emit == EMIT_LINE) |-> (idx < count), "line read past count")
  `SLE_ASSERT(a_done_clears, (cmd.emit == EMIT_DONE) |=> (count == '0 && result_valid && last_of_run), "done marker did not close the line")
  `SLE_ASSERT(a_emit_when_free, (cmd.emit != EMIT_NONE) |-> sts.slot_free, "result loaded over a pending transfer")

endmodule

>>> rtl/core/sle_ctrl.sv
// Controller state machine of the line editor.
// Depends on sle_pkg; sequences sle_datapath through command and status structs.
module sle_ctrl
  import sle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic key_valid,
  output logic key_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    key_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        key_ready = 1'b1;
        if (key_valid) begin
          cmd.accept = 1'b1;
          unique case (sts.cls)
            KC_ERASE: begin
              cmd.dec_count = !sts.count_zero;
              state_next    = S_CHECK;
            end
            KC_ABORT: begin
              cmd.clr_count = 1'b1;
              state_next    = S_ABORT;
            end
            KC_CR: begin
              cmd.store_key = 1'b1;
              state_next    = S_STORE_LF;
            end
            KC_PLAIN: begin
              cmd.store_key = 1'b1;
              state_next    = S_CHECK;
            end
            default: state_next = S_CHECK;
          endcase
        end
      end
      S_STORE_LF: begin
        cmd.store_lf = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.has_echo) begin
          state_next = S_ECHO;
        end else if (sts.ended_now) begin
          state_next = S_PREP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ECHO: begin
        if (sts.slot_free) begin
          cmd.emit = EMIT_ECHO;
          if (sts.echo_last) begin
            state_next = sts.ended ? S_PREP : S_IDLE;
          end
        end
      end
      S_PREP: begin
        cmd.rd_first = 1'b1;
        state_next   = sts.count_zero ? S_DONE : S_DUMP;
      end
      S_DUMP: begin
        if (sts.slot_free) begin
          cmd.emit = EMIT_LINE;
          if (sts.dump_last) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (sts.slot_free) begin
          cmd.emit   = EMIT_DONE;
          state_next = S_IDLE;
        end
      end
      S_ABORT: begin
        if (sts.slot_free) begin
          cmd.emit   = EMIT_ABORT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/serial_line_editor.sv
// Top level of the serial line editor: register port, controller and datapath.
// Depends on sle_pkg, sle_ctrl and sle_datapath.
//
// Usage: one received character is a transfer on key_valid/key_ready; each
// result (echo byte, stored line byte, done or abort marker) is a transfer on
// result_valid/result_ready, with last_of_run marking the final result that a
// character causes. line_size is written through the register port at
// address 0 while the block is idle.
// Throughput: one character at a time. A character is taken in S_IDLE,
// passes S_STORE_LF for a carriage return and then S_CHECK, and sends its
// echo bytes from S_ECHO; an escape goes straight to S_ABORT. Ending a line
// goes through S_PREP, S_DUMP and S_DONE, one stored byte per cycle read
// from the line store while the receiver takes each result.
// The output register lets the next character be taken while the last
// result of the previous one still waits.
// Reset: count cleared, line_size set to 32, no result pending; the line
// store is not cleared and only its entries below the count are sent out.
// A stalled receiver holds the current result and pauses the sequence.
module serial_line_editor
  import sle_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        key_valid,
  output logic        key_ready,
  input  logic [7:0]  key_char,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  result_byte,
  output logic        last_of_run
);

  logic [5:0] line_size;
  logic       hit_line_size;
  cmd_t       cmd;
  sts_t       sts;

  assign pready        = 1'b1;
  assign hit_line_size = (32'(paddr[2]) == 32'(REG_LINE_SIZE));

  always_ff @(posedge clk) begin
    if (rst) begin
      line_size <= LINE_SIZE_RST;
    end else if (psel && penable && pwrite && pready && hit_line_size) begin
      line_size <= pwdata[5:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit_line_size) begin
      prdata = 32'(line_size);
    end
  end

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sle_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .key_char     (key_char),
    .line_size    (line_size),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_kind  (result_kind),
    .result_byte  (result_byte),
    .last_of_run  (last_of_run)
  );

endmodule

>>> test/serial_line_editor_tb.sv
// Testbench for serial_line_editor: directed keys, then random lines under
// several line_size settings, checked against an in-bench line editor model.
// Depends on sle_pkg and the serial_line_editor RTL.
`timescale 1ns / 100ps

module serial_line_editor_tb;
  import sle_pkg::*;

  localparam int DEPTH = LINE_DEPTH_DEF;
  localparam logic [2:0] LINE_SIZE_ADDR = 3'(4 * REG_LINE_SIZE);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0]      key;
    logic            fixed;
    logic [1:0]      n_fix;
    res_t [0:2]      fix;
  } row_t;

  localparam res_t NO_RES = '0;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        key_valid;
  logic        key_ready;
  logic [7:0]  key_char;
  logic        result_valid;
  logic        result_ready;
  logic [1:0]  result_kind;
  logic [7:0]  result_byte;
  logic        last_of_run;

  logic [7:0] buf_mem [DEPTH];
  logic [5:0] buf_count;
  logic [5:0] size_cfg;
  res_t       step_out [$];
  res_t       out_due [$];
  bit         quiet_phase;
  int         errors;
  int         keys_sent;
  int         results_seen;
  int         settings;

  serial_line_editor #(
    .LINE_DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .key_valid(key_valid),
    .key_ready(key_ready),
    .key_char(key_char),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_kind(result_kind),
    .result_byte(result_byte),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("serial_line_editor test failed");
    $finish;
  end

  function automatic res_t mk(input logic [1:0] kind, input logic [7:0] data,
                              input logic last);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    return r;
  endfunction

  function automatic row_t key_row(input logic [7:0] key, input logic fixed,
                                   input logic [1:0] n, input res_t a,
                                   input res_t b, input res_t c);
    row_t r;
    r.key = key;
    r.fixed = fixed;
    r.n_fix = n;
    r.fix = {a, b, c};
    return r;
  endfunction

  function automatic void store_char(input logic [7:0] b);
    if (int'(buf_count) < DEPTH - 1) begin
      buf_mem[buf_count] = b;
      buf_count++;
    end
  endfunction

  function automatic void edit_line(input logic [7:0] c);
    int sz;
    int lim;
    logic [7:0] ch;
    step_out.delete();
    sz = int'(size_cfg);
    if (sz < 3) sz = 3;
    if (sz > DEPTH) sz = DEPTH;
    lim = sz - 2;
    ch = c;
    case (c)
      K_XON, K_XOFF: ;
      K_BS, K_DEL: begin
        if (buf_count != 0) begin
          buf_count--;
          step_out.push_back(mk(KIND_ECHO, K_BS, 1'b0));
          step_out.push_back(mk(KIND_ECHO, K_SPACE, 1'b0));
          step_out.push_back(mk(KIND_ECHO, K_BS, 1'b0));
        end
      end
      K_ESC: begin
        buf_count = '0;
        step_out.push_back(mk(KIND_ABORT, 8'h00, 1'b1));
        return;
      end
      default: begin
        if (c == K_CR) begin
          store_char(K_CR);
          ch = K_LF;
        end
        store_char(ch);
        step_out.push_back(mk(KIND_ECHO, ch, 1'b0));
      end
    endcase
    if (ch == K_LF || int'(buf_count) >= lim) begin
      for (int i = 0; i < int'(buf_count); i++)
        step_out.push_back(mk(KIND_LINE, buf_mem[i], 1'b0));
      step_out.push_back(mk(KIND_DONE, 8'h00, 1'b0));
      buf_count = '0;
    end
    if (step_out.size() != 0) step_out[$].last = 1'b1;
  endfunction

  function automatic int pick_gap();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 65) return 0;
    if (w < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [7:0] pick_key();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 55) return 8'($urandom_range(8'h7E, 8'h20));
    if (w < 62) return w[0] ? K_BS : K_DEL;
    if (w < 67) return K_CR;
    if (w < 71) return K_LF;
    if (w < 73) return K_ESC;
    if (w < 76) return w[0] ? K_XON : K_XOFF;
    return 8'($urandom());
  endfunction

  task automatic send_key(input row_t r, output int produced);
    @(negedge clk);
    key_valid <= 1'b1;
    key_char <= r.key;
    do @(posedge clk); while (!key_ready);
    edit_line(r.key);
    produced = step_out.size();
    if (r.fixed) begin
      for (int i = 0; i < int'(r.n_fix); i++) out_due.push_back(r.fix[i]);
    end else begin
      foreach (step_out[i]) out_due.push_back(step_out[i]);
    end
    keys_sent++;
  endtask

  task automatic key_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      key_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    while (out_due.size() != 0) @(posedge clk);
    repeat (DEPTH + 12) @(posedge clk);
  endtask

  task automatic set_line_size(input logic [5:0] v);
    logic [31:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LINE_SIZE_ADDR;
    pwdata <= {26'($urandom()), v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    size_cfg = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got[5:0] !== v) begin
      $error("line_size readback: expected %0d, got %0d", v, got[5:0]);
      errors++;
    end
    settings++;
  endtask

  initial begin : rx_side
    int stall;
    stall = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        result_ready <= 1'b0;
        stall--;
      end else begin
        result_ready <= 1'b1;
        if (!quiet_phase) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst && result_valid && result_ready) begin
      if (out_due.size() == 0) begin
        $error("unexpected result: kind %0d, byte %h, last %0d",
               result_kind, result_byte, last_of_run);
        errors++;
      end else begin
        want = out_due.pop_front();
        results_seen++;
        if (result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
          errors++;
        end
        if (result_byte !== want.data) begin
          $error("result_byte: expected %h, got %h", want.data, result_byte);
          errors++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
          errors++;
        end
      end
    end
  end

  initial begin : main
    row_t       rows [$];
    logic [5:0] sizes [9];
    int         produced;
    int         phase_n;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    key_valid = 1'b0;
    key_char = '0;
    quiet_phase = 1'b0;
    errors = 0;
    keys_sent = 0;
    results_seen = 0;
    settings = 0;
    buf_count = '0;
    size_cfg = LINE_SIZE_RST;
    foreach (buf_mem[i]) buf_mem[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rows = '{
      key_row(K_BS, 1, 0, NO_RES, NO_RES, NO_RES),
      key_row(K_DEL, 1, 0, NO_RES, NO_RES, NO_RES),
      key_row(K_XON, 1, 0, NO_RES, NO_RES, NO_RES),
      key_row(K_XOFF, 1, 0, NO_RES, NO_RES, NO_RES),
      key_row(K_ESC, 1, 1, mk(KIND_ABORT, 8'h00, 1), NO_RES, NO_RES),
      key_row(8'h41, 1, 1, mk(KIND_ECHO, 8'h41, 1), NO_RES, NO_RES),
      key_row(8'h00, 1, 1, mk(KIND_ECHO, 8'h00, 1), NO_RES, NO_RES),
      key_row(8'hFF, 1, 1, mk(KIND_ECHO, 8'hFF, 1), NO_RES, NO_RES),
      key_row(K_BS, 1, 3, mk(KIND_ECHO, K_BS, 0), mk(KIND_ECHO, K_SPACE, 0),
              mk(KIND_ECHO, K_BS, 1)),
      key_row(K_DEL, 1, 3, mk(KIND_ECHO, K_BS, 0), mk(KIND_ECHO, K_SPACE, 0),
              mk(KIND_ECHO, K_BS, 1)),
      key_row(K_ESC, 1, 1, mk(KIND_ABORT, 8'h00, 1), NO_RES, NO_RES),
      key_row(8'h68, 0, 0, NO_RES, NO_RES, NO_RES),
      key_row(8'h69, 0, 0, NO_RES, NO_RES, NO_RES),
      key_row(K_CR, 0, 0, NO_RES, NO_RES, NO_RES),
      key_row(8'h78, 0, 0, NO_RES, NO_RES, NO_RES),
      key_row(K_LF, 0, 0, NO_RES, NO_RES, NO_RES),
      key_row(K_LF, 0, 0, NO_RES, NO_RES, NO_RES),
      key_row(8'h80, 1, 1, mk(KIND_ECHO, 8'h80, 1), NO_RES, NO_RES),
      key_row(8'h71, 0, 0, NO_RES, NO_RES, NO_RES),
      key_row(8'h72, 0, 0, NO_RES, NO_RES, NO_RES),
      key_row(8'hAA, 0, 0, NO_RES, NO_RES, NO_RES),
      key_row(8'h55, 0, 0, NO_RES, NO_RES, NO_RES)
    };
    foreach (rows[i]) begin
      send_key(rows[i], produced);
      key_gap(pick_gap());
    end
    key_gap(1);
    drain();

    // shrink the limit below the current count; an ignored key ends the line
    sizes = '{6'd3, 6'd0, 6'd63, 6'd4, 6'd1, 6'd33, 6'd2,
              6'($urandom_range(31, 5)), 6'd32};
    foreach (sizes[p]) begin
      set_line_size(sizes[p]);
      quiet_phase = ($urandom_range(2) == 0);
      phase_n = 0;
      if (p == 0) begin
        send_key(key_row(K_XON, 0, 0, NO_RES, NO_RES, NO_RES), produced);
        if (produced != 0) phase_n++;
      end
      while (phase_n < 30) begin
        send_key(key_row(pick_key(), 0, 0, NO_RES, NO_RES, NO_RES), produced);
        if (produced != 0) phase_n++;
        key_gap(quiet_phase ? 0 : pick_gap());
      end
      key_gap(1);
      drain();
      quiet_phase = 1'b0;
    end

    repeat (50) @(posedge clk);
    $display("%0d keys sent, %0d results checked across %0d line_size settings",
             keys_sent, results_seen, settings);
    if (errors == 0 && out_due.size() == 0) begin
      $display("serial_line_editor test passed");
    end else begin
      $display("serial_line_editor test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/sle_pkg.sv
rtl/core/sle_datapath.sv
rtl/core/sle_ctrl.sv
rtl/core/serial_line_editor.sv
test/serial_line_editor_tb.sv
